FILE: rtl/c_like_source_tokenizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Concurrent checks clocked on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef C_LIKE_SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`define C_LIKE_SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSLT_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("tokenizer check failed");
`define CSLT_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("tokenizer check failed");
`else
`define CSLT_ASSERT_IMP(lbl, a, c)
`define CSLT_ASSERT_NXT(lbl, a, c)
`endif
`endif

FILE: rtl/cslt_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared types, codes and lookup functions of the source tokenizer.
// ----------------------------------------------------------------------------
package cslt_pkg;

    localparam int STRING_LIMIT_DEF  = 256;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QDEPTH            = 4;
    localparam logic [15:0] MAX_TOKENS_RST = 16'd4096;

    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_TOO_MANY   = 2'd0;
    localparam logic [1:0] ERR_STR_LONG   = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    localparam logic [5:0] TK_END   = 6'd0;
    localparam logic [5:0] TK_NUM   = 6'd1;
    localparam logic [5:0] TK_IDENT = 6'd2;
    localparam logic [5:0] TK_STR   = 6'd3;
    localparam logic [5:0] TK_KW0   = 6'd4;
    localparam logic [5:0] TK_OP0   = 6'd23;

    typedef enum logic [3:0] {
        M_IDLE, M_ZERO, M_DEC, M_HEX, M_IDENT, M_STR, M_ESC, M_SLASH,
        M_LINE, M_BLOCK, M_BSTAR, M_OPPEND, M_DROP
    } t_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  tk;
        logic [15:0] idx;
        logic [63:0] num;
        logic [15:0] st;
        logic [15:0] ln;
        logic [7:0]  ch;
        logic [1:0]  ec;
    } t_result;

    // one accepted byte yields up to two results; a push holds one or two
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_push;

    typedef struct packed {
        logic       hit;
        logic [5:0] kind;
    } t_op;

    function automatic t_op op2(input logic [7:0] a, input logic [7:0] b);
        t_op o;
        o.hit = 1'b1;
        unique case ({a, b})
            "==": o.kind = TK_OP0 + 6'd0;
            "!=": o.kind = TK_OP0 + 6'd1;
            "<=": o.kind = TK_OP0 + 6'd2;
            ">=": o.kind = TK_OP0 + 6'd3;
            "&&": o.kind = TK_OP0 + 6'd4;
            "||": o.kind = TK_OP0 + 6'd5;
            "<<": o.kind = TK_OP0 + 6'd6;
            ">>": o.kind = TK_OP0 + 6'd7;
            "++": o.kind = TK_OP0 + 6'd8;
            "--": o.kind = TK_OP0 + 6'd9;
            "+=": o.kind = TK_OP0 + 6'd10;
            "-=": o.kind = TK_OP0 + 6'd11;
            "*=": o.kind = TK_OP0 + 6'd12;
            "/=": o.kind = TK_OP0 + 6'd13;
            default: begin
                o.hit  = 1'b0;
                o.kind = TK_END;
            end
        endcase
        return o;
    endfunction

    function automatic t_op op1(input logic [7:0] a);
        t_op o;
        o.hit = 1'b1;
        unique case (a)
            "(": o.kind = TK_OP0 + 6'd14;
            ")": o.kind = TK_OP0 + 6'd15;
            "{": o.kind = TK_OP0 + 6'd16;
            "}": o.kind = TK_OP0 + 6'd17;
            ";": o.kind = TK_OP0 + 6'd18;
            ",": o.kind = TK_OP0 + 6'd19;
            "+": o.kind = TK_OP0 + 6'd20;
            "-": o.kind = TK_OP0 + 6'd21;
            "*": o.kind = TK_OP0 + 6'd22;
            "/": o.kind = TK_OP0 + 6'd23;
            "%": o.kind = TK_OP0 + 6'd24;
            "=": o.kind = TK_OP0 + 6'd25;
            "<": o.kind = TK_OP0 + 6'd26;
            ">": o.kind = TK_OP0 + 6'd27;
            "!": o.kind = TK_OP0 + 6'd28;
            "&": o.kind = TK_OP0 + 6'd29;
            "|": o.kind = TK_OP0 + 6'd30;
            "^": o.kind = TK_OP0 + 6'd31;
            "~": o.kind = TK_OP0 + 6'd32;
            default: begin
                o.hit  = 1'b0;
                o.kind = TK_END;
            end
        endcase
        return o;
    endfunction

    function automatic logic leads_pair(input logic [7:0] c);
        return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" ||
               c == "|" || c == "+" || c == "-" || c == "*" || c == "/";
    endfunction

    // window holds the last six bytes, newest in the low byte
    function automatic logic [5:0] kw_kind(input logic [47:0] w, input logic [2:0] n);
        logic [5:0] k;
        k = TK_IDENT;
        unique case (n)
            3'd2: begin
                unique case (w[15:0])
                    "U0": k = TK_KW0 + 6'd0;
                    "U8": k = TK_KW0 + 6'd5;
                    "I8": k = TK_KW0 + 6'd8;
                    "if": k = TK_KW0 + 6'd12;
                    default: k = TK_IDENT;
                endcase
            end
            3'd3: begin
                unique case (w[23:0])
                    "I64": k = TK_KW0 + 6'd1;
                    "U64": k = TK_KW0 + 6'd2;
                    "Str": k = TK_KW0 + 6'd4;
                    "U16": k = TK_KW0 + 6'd6;
                    "U32": k = TK_KW0 + 6'd7;
                    "I16": k = TK_KW0 + 6'd9;
                    "I32": k = TK_KW0 + 6'd10;
                    "F64": k = TK_KW0 + 6'd11;
                    "for": k = TK_KW0 + 6'd15;
                    default: k = TK_IDENT;
                endcase
            end
            3'd4: begin
                unique case (w[31:0])
                    "Bool": k = TK_KW0 + 6'd3;
                    "else": k = TK_KW0 + 6'd13;
                    "true": k = TK_KW0 + 6'd17;
                    default: k = TK_IDENT;
                endcase
            end
            3'd5: begin
                unique case (w[39:0])
                    "while": k = TK_KW0 + 6'd14;
                    "false": k = TK_KW0 + 6'd18;
                    default: k = TK_IDENT;
                endcase
            end
            3'd6: k = (w == "return") ? TK_KW0 + 6'd16 : TK_IDENT;
            default: k = TK_IDENT;
        endcase
        return k;
    endfunction

    function automatic t_result mk(input logic [1:0] kind, input logic [5:0] tk,
                                   input logic [15:0] idx, input logic [63:0] num,
                                   input logic [15:0] st, input logic [15:0] ln,
                                   input logic [7:0] ch, input logic [1:0] ec);
        t_result r;
        r.kind = kind;
        r.tk   = tk;
        r.idx  = idx;
        r.num  = num;
        r.st   = st;
        r.ln   = ln;
        r.ch   = ch;
        r.ec   = ec;
        return r;
    endfunction

endpackage

FILE: rtl/cslt_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Lexer FSM: takes one byte per cycle while i_accept is high; forms results.
// ----------------------------------------------------------------------------
module cslt_front #(
    parameter int STRING_LIMIT  = cslt_pkg::STRING_LIMIT_DEF,
    parameter int POSITION_BITS = cslt_pkg::POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output cslt_pkg::t_push   o_data
);
    localparam int STR_W = $clog2(STRING_LIMIT + 1);

    cslt_pkg::t_mode              r_mode, n_mode;
    logic [7:0]                   r_pend, n_pend;
    logic [63:0]                  r_acc, n_acc;
    logic                         r_hex, n_hex;
    logic [47:0]                  r_win, n_win;
    logic [POSITION_BITS-1:0]     r_len, n_len;
    logic [POSITION_BITS-1:0]     r_start, n_start;
    logic [POSITION_BITS-1:0]     r_pos, n_pos;
    logic [15:0]                  r_tc, n_tc;
    logic [STR_W-1:0]             r_slen, n_slen;
    logic [15:0]                  r_max;

    cslt_pkg::t_result            rs [2];
    logic [1:0]                   nr;
    logic                         do_beg;
    logic [7:0]                   bc;
    logic [7:0]                   c;
    logic                         c_dig, c_alpha, c_hexd;
    logic [3:0]                   dval, hval;
    cslt_pkg::t_op                o2, o1;
    logic [5:0]                   ikind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cslt_pkg::M_IDLE;
            r_pend  <= '0;
            r_acc   <= '0;
            r_hex   <= 1'b0;
            r_win   <= '0;
            r_len   <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_tc    <= '0;
            r_slen  <= '0;
            r_max   <= cslt_pkg::MAX_TOKENS_RST;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_mode  <= n_mode;
                r_pend  <= n_pend;
                r_acc   <= n_acc;
                r_hex   <= n_hex;
                r_win   <= n_win;
                r_len   <= n_len;
                r_start <= n_start;
                r_pos   <= n_pos;
                r_tc    <= n_tc;
                r_slen  <= n_slen;
            end
        end
    end

    assign c       = i_byte;
    assign c_dig   = (c >= "0") && (c <= "9");
    assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    assign dval    = 4'(c - "0");
    always_comb begin
        c_hexd = 1'b1;
        hval   = dval;
        priority if (c_dig) begin
            hval = dval;
        end else if ((c >= "a") && (c <= "f")) begin
            hval = 4'(c - "a" + 8'd10);
        end else if ((c >= "A") && (c <= "F")) begin
            hval = 4'(c - "A" + 8'd10);
        end else begin
            c_hexd = 1'b0;
        end
    end
    assign o2    = cslt_pkg::op2(r_pend, c);
    assign o1    = cslt_pkg::op1(r_pend);
    assign ikind = (r_len > POSITION_BITS'(6)) ? cslt_pkg::TK_IDENT
                 : cslt_pkg::kw_kind(r_win, r_len[2:0]);

    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_acc   = r_acc;
        n_hex   = r_hex;
        n_win   = r_win;
        n_len   = r_len;
        n_start = r_start;
        n_tc    = r_tc;
        n_slen  = r_slen;
        n_pos   = r_pos;
        nr      = 2'd0;
        rs[0]   = '0;
        rs[1]   = '0;
        do_beg  = 1'b0;
        bc      = c;

        unique case (r_mode)
            cslt_pkg::M_ZERO, cslt_pkg::M_DEC, cslt_pkg::M_HEX: begin
                if (r_mode == cslt_pkg::M_ZERO && (c == "x" || c == "X")) begin
                    n_hex  = 1'b1;
                    n_mode = cslt_pkg::M_HEX;
                end else if (r_hex && c_hexd) begin
                    n_acc = {r_acc[59:0], 4'b0} + {60'b0, hval};
                end else if (!r_hex && c_dig) begin
                    n_mode = cslt_pkg::M_DEC;
                    n_acc  = {r_acc[60:0], 3'b0} + {r_acc[62:0], 1'b0} + {60'b0, dval};
                end else begin
                    rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, cslt_pkg::TK_NUM,
                                             n_tc, r_acc, '0, '0, '0, '0);
                    nr     = nr + 2'd1;
                    n_tc   = n_tc + 16'd1;
                    do_beg = 1'b1;
                end
            end
            cslt_pkg::M_IDENT: begin
                if (c_alpha || c_dig) begin
                    if (r_len != '1) begin
                        n_len = r_len + 1'b1;
                    end
                    n_win = {r_win[39:0], c};
                end else begin
                    rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, ikind, n_tc, '0,
                                             16'(r_start), 16'(r_len), '0, '0);
                    nr     = nr + 2'd1;
                    n_tc   = n_tc + 16'd1;
                    do_beg = 1'b1;
                end
            end
            cslt_pkg::M_STR, cslt_pkg::M_ESC: begin
                if (c == 8'd0 || (r_mode == cslt_pkg::M_STR && c == "\"")) begin
                    rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, cslt_pkg::TK_STR,
                                             n_tc, '0, '0, 16'(r_slen), '0, '0);
                    nr     = nr + 2'd1;
                    n_tc   = n_tc + 16'd1;
                    do_beg = 1'b1;
                    bc     = (c == 8'd0) ? 8'd0 : " ";
                end else if (r_mode == cslt_pkg::M_STR && c == "\\") begin
                    n_mode = cslt_pkg::M_ESC;
                end else begin
                    n_mode = cslt_pkg::M_STR;
                    bc = c;
                    if (r_mode == cslt_pkg::M_ESC) begin
                        unique case (c)
                            "n":     bc = 8'h0a;
                            "t":     bc = 8'h09;
                            "r":     bc = 8'h0d;
                            default: bc = c;
                        endcase
                    end
                    rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_CHAR, '0, '0, '0, '0, '0,
                                             bc, '0);
                    nr     = nr + 2'd1;
                    n_slen = r_slen + 1'b1;
                    if (n_slen >= STR_W'(STRING_LIMIT)) begin
                        rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_ERROR, '0, '0, '0, '0,
                                                 '0, '0, cslt_pkg::ERR_STR_LONG);
                        nr     = nr + 2'd1;
                        n_mode = cslt_pkg::M_DROP;
                    end
                end
            end
            cslt_pkg::M_SLASH: begin
                // the pending byte is not kept for a slash: its codes are fixed
                priority if (c == "/") begin
                    n_mode = cslt_pkg::M_LINE;
                end else if (c == "*") begin
                    n_mode = cslt_pkg::M_BLOCK;
                end else if (n_tc >= r_max) begin
                    rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_ERROR, '0, '0, '0, '0, '0,
                                             '0, cslt_pkg::ERR_TOO_MANY);
                    nr     = nr + 2'd1;
                    n_mode = cslt_pkg::M_DROP;
                end else if (c == "=") begin
                    rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, cslt_pkg::TK_OP0 + 6'd13,
                                             n_tc, '0, '0, '0, '0, '0);
                    nr     = nr + 2'd1;
                    n_tc   = n_tc + 16'd1;
                    n_mode = cslt_pkg::M_IDLE;
                end else begin
                    rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, cslt_pkg::TK_OP0 + 6'd23,
                                             n_tc, '0, '0, '0, '0, '0);
                    nr     = nr + 2'd1;
                    n_tc   = n_tc + 16'd1;
                    do_beg = 1'b1;
                end
            end
            cslt_pkg::M_LINE: begin
                if (c == 8'h0a) begin
                    n_mode = cslt_pkg::M_IDLE;
                end else if (c == 8'd0) begin
                    do_beg = 1'b1;
                end
            end
            cslt_pkg::M_BLOCK, cslt_pkg::M_BSTAR: begin
                priority if (c == 8'd0) begin
                    do_beg = 1'b1;
                end else if (r_mode == cslt_pkg::M_BSTAR && c == "/") begin
                    n_mode = cslt_pkg::M_IDLE;
                end else begin
                    n_mode = (c == "*") ? cslt_pkg::M_BSTAR : cslt_pkg::M_BLOCK;
                end
            end
            cslt_pkg::M_OPPEND: begin
                if (o2.hit) begin
                    rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, o2.kind, n_tc, '0,
                                             '0, '0, '0, '0);
                    nr     = nr + 2'd1;
                    n_tc   = n_tc + 16'd1;
                    n_mode = cslt_pkg::M_IDLE;
                end else begin
                    if (o1.hit) begin
                        rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, o1.kind, n_tc, '0,
                                                 '0, '0, '0, '0);
                        nr   = nr + 2'd1;
                        n_tc = n_tc + 16'd1;
                    end
                    do_beg = 1'b1;
                end
            end
            cslt_pkg::M_DROP: begin
                n_mode = cslt_pkg::M_DROP;
            end
            default: begin
                do_beg = 1'b1;
            end
        endcase

        // start of a new token
        if (do_beg) begin
            n_mode = cslt_pkg::M_IDLE;
            priority if (bc == " " || bc == 8'h09 || bc == 8'h0d || bc == 8'h0a) begin
                n_mode = cslt_pkg::M_IDLE;
            end else if (bc == "/") begin
                n_mode = cslt_pkg::M_SLASH;
            end else if (n_tc >= r_max) begin
                rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0,
                                         cslt_pkg::ERR_TOO_MANY);
                nr     = nr + 2'd1;
                n_mode = cslt_pkg::M_DROP;
            end else if (bc == 8'd0) begin
                rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, cslt_pkg::TK_END, n_tc,
                                         '0, '0, '0, '0, '0);
                nr   = nr + 2'd1;
                n_tc = n_tc + 16'd1;
            end else if (c_dig) begin
                n_acc  = {60'b0, dval};
                n_hex  = 1'b0;
                n_mode = (c == "0") ? cslt_pkg::M_ZERO : cslt_pkg::M_DEC;
            end else if (c_alpha) begin
                n_start = r_pos;
                n_len   = POSITION_BITS'(1);
                n_win   = {40'b0, c};
                n_mode  = cslt_pkg::M_IDENT;
            end else if (c == "\"") begin
                n_slen = '0;
                n_mode = cslt_pkg::M_STR;
            end else if (cslt_pkg::leads_pair(c)) begin
                n_pend = c;
                n_mode = cslt_pkg::M_OPPEND;
            end else if (cslt_pkg::op1(c).hit) begin
                rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_TOKEN, cslt_pkg::op1(c).kind,
                                         n_tc, '0, '0, '0, '0, '0);
                nr   = nr + 2'd1;
                n_tc = n_tc + 16'd1;
            end else begin
                rs[nr[0]] = cslt_pkg::mk(cslt_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0,
                                         cslt_pkg::ERR_UNEXPECTED);
                nr     = nr + 2'd1;
                n_mode = cslt_pkg::M_DROP;
            end
        end

        // end of text resets position and count
        if (c == 8'd0) begin
            n_mode = cslt_pkg::M_IDLE;
            n_pos  = '0;
            n_tc   = '0;
        end else if (r_pos != '1) begin
            n_pos = r_pos + 1'b1;
        end
    end

    assign o_push    = i_accept && (nr != 2'd0);
    assign o_data.two = (nr == 2'd2);
    assign o_data.r0  = rs[0];
    assign o_data.r1  = rs[1];

endmodule

FILE: rtl/cslt_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Queue of result pairs and the output stage that sends them one by one.
// ----------------------------------------------------------------------------
`include "c_like_source_tokenizer_unit_assert.svh"

module cslt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cslt_pkg::t_push  i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_take,
    output cslt_pkg::t_result o_res,
    output logic             o_last
);
    localparam int PW = $clog2(cslt_pkg::QDEPTH);

    cslt_pkg::t_push  r_mem [cslt_pkg::QDEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;
    logic             r_sub;
    cslt_pkg::t_push  head;
    logic             pop;

    assign head    = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_ready = (r_cnt < (PW+1)'(cslt_pkg::QDEPTH));
    assign o_res   = r_sub ? head.r1 : head.r0;
    assign o_last  = r_sub || !head.two;
    assign pop     = o_valid && i_take && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_sub <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (o_valid && i_take) begin
                // advance to the second result of the pair, or drop the pair
                r_sub <= !o_last;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(pop);
        end
    end

    `CSLT_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= (PW+1)'(cslt_pkg::QDEPTH))
    `CSLT_ASSERT_IMP(a_no_overflow, i_push, o_ready)
    `CSLT_ASSERT_IMP(a_sub_pair, r_sub, o_valid && head.two)
    `CSLT_ASSERT_NXT(a_drain, pop && !i_push && r_cnt == (PW+1)'(1), !o_valid)

endmodule

FILE: rtl/c_like_source_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// C-like source tokenizer
// Streams source bytes in and tokens, string characters and errors out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while the four-entry result queue has
// room. A byte yields zero, one or two results, and the output port sends
// one result per cycle while i_m_tready is high, so a run of bytes with two
// results each drains slower than the bytes come in and the queue fills
// until the input stalls. The first result of a byte can be taken at the
// clock edge right after the one that accepts the byte. No clearing pass
// is needed after reset.
module c_like_source_tokenizer_unit #(
    parameter int STRING_LIMIT  = cslt_pkg::STRING_LIMIT_DEF,
    parameter int POSITION_BITS = cslt_pkg::POSITION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,   // max_tokens
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,     // source_byte
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // token_kind, token_index, number_value, text_start, text_length,
    // char_value, error_code (lowest bit up)
    output logic [127:0] o_m_tdata,
    output logic [1:0]   o_m_tuser,     // result_kind
    output logic         o_m_tlast      // last_result
);
    cslt_pkg::t_push   push_data;
    cslt_pkg::t_result res;
    logic              push;
    logic              accept;

    assign accept = i_s_tvalid && o_s_tready;

    cslt_front #(
        .STRING_LIMIT  (STRING_LIMIT),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .o_push      (push),
        .o_data      (push_data)
    );

    cslt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_take  (i_m_tready),
        .o_res   (res),
        .o_last  (o_m_tlast)
    );

    assign o_m_tuser = res.kind;
    assign o_m_tdata = {res.ec, res.ch, res.ln, res.st, res.num, res.idx, res.tk};

endmodule
